// File: rtl/itr_pkg.sv
// Shared types, constants and a helper function for the integer to radix text block.
package itr_pkg;

    localparam int WORD_W      = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int DIV_BITS    = 4;
    localparam int DIV_CYCLES  = WORD_W / DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_CYCLES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_BIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CHAR_B     = 7'h62;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [RADIX_W-1:0]       radix;
    } itr_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } itr_out_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_OCT,
        PFX_HEX,
        PFX_BIN
    } itr_prefix_t;

    typedef struct packed {
        logic [WORD_W-1:0]  magnitude;
        logic [RADIX_W-1:0] radix;
        logic               is_zero;
        logic               negative;
        itr_prefix_t        prefix;
    } itr_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_PFX0,
        ST_PFX1,
        ST_READ,
        ST_SEND,
        ST_ZERO
    } itr_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d < 6'd10) begin
            digit_char = CHAR_ZERO + d_ext;
        end else begin
            digit_char = CHAR_A + (d_ext - 7'd10);
        end
    endfunction

endpackage

// File: rtl/itr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module itr_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/itr_front.sv
// Input stage: accepts items, drops bad bases and classifies each number into a job.
module itr_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  itr_pkg::itr_in_t  s_data,
    input  logic              q_ready,
    output logic              q_push,
    output itr_pkg::itr_job_t q_job
);

    logic                           radix_ok;
    logic                           negative;
    logic [itr_pkg::WORD_W-1:0]     pattern;
    itr_pkg::itr_prefix_t           prefix;

    assign s_ready  = q_ready;
    assign radix_ok = (s_data.radix >= itr_pkg::RADIX_MIN) &&
                      (s_data.radix <= itr_pkg::RADIX_MAX);
    assign q_push   = s_valid && s_ready && radix_ok;
    assign pattern  = s_data.value;
    assign negative = (s_data.radix == itr_pkg::RADIX_DEC) && pattern[itr_pkg::WORD_W-1];

    always_comb begin
        unique case (s_data.radix)
            itr_pkg::RADIX_HEX: prefix = itr_pkg::PFX_HEX;
            itr_pkg::RADIX_OCT: prefix = itr_pkg::PFX_OCT;
            itr_pkg::RADIX_BIN: prefix = itr_pkg::PFX_BIN;
            default:            prefix = itr_pkg::PFX_NONE;
        endcase
    end

    always_comb begin
        q_job.magnitude = negative ? (~pattern + 32'd1) : pattern;
        q_job.radix     = s_data.radix;
        q_job.is_zero   = (pattern == '0);
        q_job.negative  = negative;
        q_job.prefix    = prefix;
    end

endmodule

// File: rtl/itr_queue.sv
// Short job queue that decouples the input stage from the conversion engine.
module itr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  itr_pkg::itr_job_t push_job,
    output logic              push_ready,
    input  logic              pop,
    output logic              pop_valid,
    output itr_pkg::itr_job_t pop_job
);

    itr_pkg::itr_job_t              slot_reg [itr_pkg::QUEUE_DEPTH];
    logic [itr_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [itr_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [itr_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = (count_reg != itr_pkg::QCNT_W'(itr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == itr_pkg::QPTR_W'(itr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == itr_pkg::QPTR_W'(itr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/itr_back.sv
// Conversion engine: iterative digit division into the digit memory, then character output.
module itr_back #(
    parameter int DIGIT_DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  itr_pkg::itr_job_t q_job,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output itr_pkg::itr_out_t m_data
);

    localparam int IDX_W = $clog2(DIGIT_DEPTH);
    localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);

    itr_pkg::itr_state_t             state_reg, state_next;
    itr_pkg::itr_job_t               job_reg, job_next;
    logic [itr_pkg::WORD_W-1:0]      work_reg, work_next;
    logic [itr_pkg::RADIX_W:0]       acc_reg, acc_next;
    logic [itr_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    itr_pkg::itr_out_t               out_reg, out_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            out_free;
    logic                            load;
    logic                            digit_done;
    logic [itr_pkg::WORD_W-1:0]      quot;
    logic [itr_pkg::RADIX_W:0]       rem;
    logic                            wr_en;
    logic [itr_pkg::RADIX_W-1:0]     rd_data;

    assign out_free   = !out_valid_reg || m_ready;
    assign digit_done = (step_reg == itr_pkg::STEP_W'(itr_pkg::DIV_CYCLES - 1));
    assign wr_en      = (state_reg == itr_pkg::ST_DIV) && digit_done;

    // Four restoring division steps per cycle on the shifting dividend.
    always_comb begin
        logic [itr_pkg::WORD_W-1:0] w;
        logic [itr_pkg::RADIX_W:0]  a;
        w = work_reg;
        a = acc_reg;
        for (int i = 0; i < itr_pkg::DIV_BITS; i++) begin
            a = {a[itr_pkg::RADIX_W-1:0], w[itr_pkg::WORD_W-1]};
            w = {w[itr_pkg::WORD_W-2:0], 1'b0};
            if (a >= {1'b0, job_reg.radix}) begin
                a    = a - {1'b0, job_reg.radix};
                w[0] = 1'b1;
            end
        end
        quot = w;
        rem  = a;
    end

    itr_ram #(
        .WIDTH (itr_pkg::RADIX_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_digits (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (rem[itr_pkg::RADIX_W-1:0]),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            itr_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = q_job.is_zero ? itr_pkg::ST_ZERO : itr_pkg::ST_DIV;
                end
            end
            itr_pkg::ST_DIV: begin
                if (digit_done && (quot == '0)) begin
                    if (job_reg.negative) begin
                        state_next = itr_pkg::ST_SIGN;
                    end else if (job_reg.prefix != itr_pkg::PFX_NONE) begin
                        state_next = itr_pkg::ST_PFX0;
                    end else begin
                        state_next = itr_pkg::ST_READ;
                    end
                end
            end
            itr_pkg::ST_SIGN: begin
                if (out_free) begin
                    state_next = (job_reg.prefix != itr_pkg::PFX_NONE) ?
                                 itr_pkg::ST_PFX0 : itr_pkg::ST_READ;
                end
            end
            itr_pkg::ST_PFX0: begin
                if (out_free) begin
                    state_next = (job_reg.prefix == itr_pkg::PFX_OCT) ?
                                 itr_pkg::ST_READ : itr_pkg::ST_PFX1;
                end
            end
            itr_pkg::ST_PFX1: begin
                if (out_free) begin
                    state_next = itr_pkg::ST_READ;
                end
            end
            itr_pkg::ST_READ: begin
                state_next = itr_pkg::ST_SEND;
            end
            itr_pkg::ST_SEND: begin
                if (out_free) begin
                    state_next = (idx_reg == '0) ? itr_pkg::ST_IDLE : itr_pkg::ST_READ;
                end
            end
            itr_pkg::ST_ZERO: begin
                if (out_free) begin
                    state_next = itr_pkg::ST_IDLE;
                end
            end
            default: state_next = itr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop              = 1'b0;
        load               = 1'b0;
        out_next           = out_reg;
        out_next.last      = 1'b0;
        unique case (state_reg)
            itr_pkg::ST_IDLE: begin
                q_pop = q_valid;
            end
            itr_pkg::ST_SIGN: begin
                load               = out_free;
                out_next.character = itr_pkg::CHAR_MINUS;
            end
            itr_pkg::ST_PFX0: begin
                load               = out_free;
                out_next.character = itr_pkg::CHAR_ZERO;
            end
            itr_pkg::ST_PFX1: begin
                load               = out_free;
                out_next.character = (job_reg.prefix == itr_pkg::PFX_HEX) ?
                                     itr_pkg::CHAR_X : itr_pkg::CHAR_B;
            end
            itr_pkg::ST_SEND: begin
                load               = out_free;
                out_next.character = itr_pkg::digit_char(rd_data);
                out_next.last      = (idx_reg == '0);
            end
            itr_pkg::ST_ZERO: begin
                load               = out_free;
                out_next.character = itr_pkg::CHAR_ZERO;
                out_next.last      = 1'b1;
            end
            default: begin
                load = 1'b0;
            end
        endcase
        if (!load) begin
            out_next = out_reg;
        end
        out_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_comb begin
        job_next   = job_reg;
        work_next  = work_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (q_pop) begin
            job_next   = q_job;
            work_next  = q_job.magnitude;
            acc_next   = '0;
            step_next  = '0;
            count_next = '0;
        end else if (state_reg == itr_pkg::ST_DIV) begin
            step_next = step_reg + 1'b1;
            if (digit_done) begin
                work_next  = quot;
                acc_next   = '0;
                count_next = count_reg + 1'b1;
                idx_next   = count_reg[IDX_W-1:0];
            end else begin
                work_next = quot;
                acc_next  = rem;
            end
        end else if ((state_reg == itr_pkg::ST_SEND) && out_free && (idx_reg != '0)) begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= itr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        work_reg <= work_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DIGIT_DEPTH))
        else $error("Digit count exceeds the digit memory depth.");

    a_read_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itr_pkg::ST_READ || state_reg == itr_pkg::ST_SEND) |->
        ({1'b0, idx_reg} < count_reg))
        else $error("Digit read beyond the digits written for this number.");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!out_valid_reg || m_ready))
        else $error("Output register overwritten before its transfer.");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && out_next.last) |=> (state_reg == itr_pkg::ST_IDLE))
        else $error("Final character sent while the number is still in progress.");

endmodule

// File: rtl/integer_to_radix_text.sv
// Top level of the integer to radix text converter.
// Each accepted item (a 32-bit value and a base from 2 to 36) becomes its text, one
// character per output transfer, most significant first, with last set on the final
// character; items with a base outside 2..36 are accepted and dropped. A nonzero value
// is first divided digit by digit (four restoring division steps per cycle over the
// 32-bit word), then any sign or prefix characters are sent, then each digit character
// through the registered digit memory read. A two-entry job queue lets new items be
// taken while a number is being converted, and the output register lets the divider
// start on the next number while the final character still waits.
module integer_to_radix_text #(
    parameter int DIGIT_DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  itr_pkg::itr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output itr_pkg::itr_out_t m_data
);

    logic              q_ready;
    logic              q_push;
    itr_pkg::itr_job_t q_push_job;
    logic              q_valid;
    logic              q_pop;
    itr_pkg::itr_job_t q_pop_job;

    itr_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_job   (q_push_job)
    );

    itr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_job    (q_pop_job)
    );

    itr_back #(
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_pop_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
